// ===== hw/rtl/rcmr_pkg.sv =====
// ----------------------------------------------------------------------------
// Rod-cutting engine package
// Field widths, operation codes, default sizes and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package rcmr_pkg;

   // Transaction field widths, fixed by the interface.
   localparam int OPERATION_W    = 1;
   localparam int LENGTH_W       = 7;
   localparam int PRICE_W        = 16;
   localparam int BEST_REVENUE_W = 22;

   // Operation codes.
   localparam logic [OPERATION_W-1:0] OP_WRITE = 1'b0;
   localparam logic [OPERATION_W-1:0] OP_SOLVE = 1'b1;

   // Default sizes.
   localparam int DEF_MAX_LENGTH = 64;
   localparam int DEF_PRICE_BITS = 16;

   // Controller to datapath.
   typedef struct packed {
      logic clr_write;    // write zero at the sweep address and advance it
      logic price_write;  // store the request price, if its length is in range
      logic solve_start;  // latch the rod length, write r[0], start row one
      logic issue;        // read price[i-1] and r[j-i], advance i
      logic rev_write;    // store the finished row maximum in r[j]
      logic next_row;     // advance j, restart i, clear the running maximum
      logic rsp_load;     // load the response register with the row maximum
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic clr_last;     // sweep address is the last price entry
      logic req_len_zero; // request length is zero
      logic i_last;       // the read being issued is the last one of the row
      logic j_last;       // the current row is the requested rod length
      logic pipe_empty;   // no read or candidate is still in flight
      logic out_free;     // response register can take a new value
   } status_type;

endpackage

// ===== hw/rtl/rcmr_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, with registered read data.
// ----------------------------------------------------------------------------
module rcmr_ram #(
   parameter  int WIDTH = 8,
   parameter  int DEPTH = 16,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/rcmr_dpath.sv =====
// ----------------------------------------------------------------------------
// Rod-cutting datapath
// Price and revenue memories, loop counters, the add and compare pipeline
// and the response register.
// ----------------------------------------------------------------------------
module rcmr_dpath import rcmr_pkg::*; #(
   parameter int MAX_LENGTH = DEF_MAX_LENGTH,
   parameter int PRICE_BITS = DEF_PRICE_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [LENGTH_W-1:0]       req_length,
   input  logic [PRICE_W-1:0]        req_price,
   input  cmd_type                   cmd,
   output status_type                status,
   input  logic                      rsp_stall,
   output logic                      rsp_valid,
   output logic [BEST_REVENUE_W-1:0] rsp_best_revenue
);

   localparam int PA = $clog2(MAX_LENGTH);      // price address bits
   localparam int LW = $clog2(MAX_LENGTH + 1);  // length, counter and r address bits
   localparam int RW = PRICE_BITS + LW;         // revenue bits, wide enough for any rod

   logic [PA-1:0]         clr_ff, clr_in;
   logic [LW-1:0]         len_ff, len_in;
   logic [LW-1:0]         j_ff, j_in;
   logic [LW-1:0]         i_ff, i_in;
   logic                  v1_ff, v1_in;
   logic                  v2_ff, v2_in;
   logic [RW-1:0]         cand_ff, cand_in;
   logic [RW-1:0]         best_ff, best_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [BEST_REVENUE_W-1:0] rsp_data_ff, rsp_data_in;

   logic                  len_in_range;
   logic [LW-1:0]         len_sat;
   logic [LENGTH_W-1:0]   len_m1;

   logic                  price_we;
   logic [PA-1:0]         price_wa;
   logic [PRICE_BITS-1:0] price_wd;
   logic [PA-1:0]         price_ra;
   logic [PRICE_BITS-1:0] price_rd;

   logic                  rev_we;
   logic [LW-1:0]         rev_wa;
   logic [RW-1:0]         rev_wd;
   logic [LW-1:0]         rev_ra;
   logic [RW-1:0]         rev_rd;

   assign len_in_range = (req_length != '0) && (32'(req_length) <= MAX_LENGTH);
   assign len_sat      = (32'(req_length) > MAX_LENGTH) ? LW'(MAX_LENGTH) : LW'(req_length);
   assign len_m1       = req_length - LENGTH_W'(1);

   // Price memory: reset sweep, or a write transaction.
   assign price_we = cmd.clr_write || (cmd.price_write && len_in_range);
   assign price_wa = cmd.clr_write ? clr_ff : PA'(len_m1);
   assign price_wd = cmd.clr_write ? '0 : PRICE_BITS'(req_price);
   assign price_ra = PA'(i_ff - LW'(1));

   // Revenue memory: r[0] at the start of a solve, r[j] at the end of a row.
   assign rev_we = cmd.solve_start || cmd.rev_write;
   assign rev_wa = cmd.solve_start ? '0 : j_ff;
   assign rev_wd = cmd.solve_start ? '0 : best_ff;
   assign rev_ra = j_ff - i_ff;

   rcmr_ram #(
      .WIDTH (PRICE_BITS),
      .DEPTH (MAX_LENGTH)
   ) u_price_ram (
      .clock   (clock),
      .wr_en   (price_we),
      .wr_addr (price_wa),
      .wr_data (price_wd),
      .rd_addr (price_ra),
      .rd_data (price_rd)
   );

   rcmr_ram #(
      .WIDTH (RW),
      .DEPTH (MAX_LENGTH + 1)
   ) u_rev_ram (
      .clock   (clock),
      .wr_en   (rev_we),
      .wr_addr (rev_wa),
      .wr_data (rev_wd),
      .rd_addr (rev_ra),
      .rd_data (rev_rd)
   );

   always_comb begin
      clr_in       = clr_ff;
      len_in       = len_ff;
      j_in         = j_ff;
      i_in         = i_ff;
      best_in      = best_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (cmd.clr_write) begin
         clr_in = clr_ff + PA'(1);
      end

      if (cmd.solve_start) begin
         len_in  = len_sat;
         j_in    = LW'(1);
         i_in    = LW'(1);
         best_in = '0;
      end else if (cmd.next_row) begin
         j_in    = j_ff + LW'(1);
         i_in    = LW'(1);
         best_in = '0;
      end else begin
         if (cmd.issue) begin
            i_in = i_ff + LW'(1);
         end
         if (v2_ff && (cand_ff > best_ff)) begin
            best_in = cand_ff;
         end
      end

      // Read data arrives in the cycle after issue; the sum is registered
      // before the compare.
      v1_in   = cmd.issue;
      v2_in   = v1_ff;
      cand_in = RW'(price_rd) + rev_rd;

      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = BEST_REVENUE_W'(best_ff);
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff      <= len_in;
      j_ff        <= j_in;
      i_ff        <= i_in;
      cand_ff     <= cand_in;
      best_ff     <= best_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign status.clr_last     = (clr_ff == PA'(MAX_LENGTH - 1));
   assign status.req_len_zero = (req_length == '0);
   assign status.i_last       = (i_ff == j_ff);
   assign status.j_last       = (j_ff == len_ff);
   assign status.pipe_empty   = !v1_ff && !v2_ff;
   assign status.out_free     = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_best_revenue = rsp_data_ff;

`ifndef ASSERT_OFF
   a_row_write_after_drain: assert property (@(posedge clock) disable iff (reset)
      cmd.rev_write |-> (!v1_ff && !v2_ff))
      else $error("row maximum stored while candidates are in flight");

   a_issue_in_row: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> ((i_ff != '0) && (i_ff <= j_ff) && (j_ff <= len_ff)))
      else $error("read issued outside the current row");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("response register overwritten while stalled");

   a_price_port_single: assert property (@(posedge clock) disable iff (reset)
      !(cmd.clr_write && cmd.price_write))
      else $error("price sweep and price write in the same cycle");
`endif

endmodule

// ===== hw/rtl/rcmr_ctrl.sv =====
// ----------------------------------------------------------------------------
// Rod-cutting controller
// Sequences the reset sweep, price writes and the row by row solve.
// ----------------------------------------------------------------------------
module rcmr_ctrl import rcmr_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [OPERATION_W-1:0] req_operation,
   input  status_type             status,
   output cmd_type                cmd
);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_INNER = 3'd2;
   localparam logic [2:0] S_DRAIN = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;

      case (state_ff)
         S_CLEAR: begin
            cmd.clr_write = 1'b1;
            if (status.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (req_operation == OP_WRITE) begin
                  cmd.price_write = 1'b1;
               end else begin
                  cmd.solve_start = 1'b1;
                  state_in = status.req_len_zero ? S_DONE : S_INNER;
               end
            end
         end
         S_INNER: begin
            cmd.issue = 1'b1;
            if (status.i_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (status.pipe_empty) begin
               cmd.rev_write = 1'b1;
               if (status.j_last) begin
                  state_in = S_DONE;
               end else begin
                  cmd.next_row = 1'b1;
                  state_in     = S_INNER;
               end
            end
         end
         S_DONE: begin
            if (status.out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hw/rtl/rod_cutting_max_revenue_top.sv =====
// ----------------------------------------------------------------------------
// Rod-cutting maximum revenue engine
// Bottom-up dynamic program over a price table, answering best revenue
// queries for a rod length.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  req_operation, req_length, req_price
// rsp_      out        rsp_valid/rsp_stall  rsp_best_revenue
//
// After reset the price memory is swept to zero, one entry per cycle, over
// all MAX_LENGTH entries; requests are stalled during the sweep.
// A price write leaves the controller idle. A solve for a rod of length L
// (clamped to MAX_LENGTH) runs row by row: the inner loop issues one
// price and one revenue memory read per cycle, and each row then waits
// until the add and compare pipeline has drained before writing r[j].
// A finished result sits in the response register, so the next request is
// taken while the result is stalled; a later solve waits at its end until
// the response register is free.
//
// The design is split into a controller state machine (rcmr_ctrl) and a
// datapath (rcmr_dpath) that holds both memories, the loop counters and the
// response register. They talk only through the command and status bundles.
// ----------------------------------------------------------------------------
module rod_cutting_max_revenue_top import rcmr_pkg::*; #(
   parameter int MAX_LENGTH = DEF_MAX_LENGTH,
   parameter int PRICE_BITS = DEF_PRICE_BITS
) (
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [OPERATION_W-1:0]    req_operation,
   input  logic [LENGTH_W-1:0]       req_length,
   input  logic [PRICE_W-1:0]        req_price,

   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [BEST_REVENUE_W-1:0] rsp_best_revenue
);

   cmd_type    cmd;
   status_type status;

   // The controller only decides when things happen; every address, count
   // and value lives in the datapath.
   rcmr_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .status        (status),
      .cmd           (cmd)
   );

   rcmr_dpath #(
      .MAX_LENGTH (MAX_LENGTH),
      .PRICE_BITS (PRICE_BITS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .req_length       (req_length),
      .req_price        (req_price),
      .cmd              (cmd),
      .status           (status),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_best_revenue (rsp_best_revenue)
   );

endmodule

// ===== tb/rod_cutting_max_revenue_checker.sv =====
// ----------------------------------------------------------------------------
// Rod-cutting revenue checker
// Watches both channels of the rod-cutting engine, keeps its own price table,
// predicts the best revenue of every accepted solve and compares it with the
// responses in order.
// ----------------------------------------------------------------------------
module rod_cutting_max_revenue_checker import rcmr_pkg::*; #(
   parameter int MAX_LEN = DEF_MAX_LENGTH
) (
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      req_valid,
   input  logic                      req_stall,
   input  logic [OPERATION_W-1:0]    req_operation,
   input  logic [LENGTH_W-1:0]       req_length,
   input  logic [PRICE_W-1:0]        req_price,

   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  logic [BEST_REVENUE_W-1:0] rsp_best_revenue,

   output int unsigned               fault_total,
   output int unsigned               pending_total,
   output int unsigned               checked_total
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REPORT_LIMIT = 10;

   logic [PRICE_W-1:0]        price_book [1:MAX_LEN];
   logic [BEST_REVENUE_W-1:0] revenue_due [$];
   logic [BEST_REVENUE_W-1:0] want;
   int unsigned               fault_count;
   int unsigned               checked_count;

   // Bottom-up table of best revenues r[0..rod]; lengths past the table clamp.
   function automatic logic [BEST_REVENUE_W-1:0] best_cut_revenue(
      input logic [LENGTH_W-1:0] rod
   );
      logic [BEST_REVENUE_W-1:0] best_for [0:MAX_LEN];
      logic [BEST_REVENUE_W-1:0] best;
      logic [BEST_REVENUE_W-1:0] cand;
      int                        span;
      span = (int'(rod) > MAX_LEN) ? MAX_LEN : int'(rod);
      best_for[0] = '0;
      for (int j = 1; j <= span; j++) begin
         best = '0;
         for (int i = 1; i <= j; i++) begin
            cand = BEST_REVENUE_W'(price_book[i]) + best_for[j-i];
            if (cand > best) best = cand;
         end
         best_for[j] = best;
      end
      return best_for[span];
   endfunction

   task automatic flag_fault(input string what);
      fault_count++;
      if (fault_count <= REPORT_LIMIT) $display("%0t ns: %s", $time, what);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         foreach (price_book[k]) price_book[k] = '0;
         revenue_due.delete();
         fault_count   = 0;
         checked_count = 0;
      end else begin
         // Responses are taken before requests, so a revenue can never match
         // a solve accepted on the same edge.
         if (rsp_valid && !rsp_stall) begin
            if (revenue_due.size() == 0) begin
               flag_fault($sformatf("unexpected revenue %0d with no solve outstanding",
                                    rsp_best_revenue));
            end else begin
               want = revenue_due.pop_front();
               checked_count++;
               if (rsp_best_revenue !== want)
                  flag_fault($sformatf("best_revenue mismatch: expected %0d, got %0d",
                                       want, rsp_best_revenue));
            end
         end
         if (req_valid && !req_stall) begin
            if (req_operation == OP_SOLVE)
               revenue_due.push_back(best_cut_revenue(req_length));
            else if (req_length >= 1 && int'(req_length) <= MAX_LEN)
               price_book[req_length] = req_price;
         end
      end
      fault_total   <= fault_count;
      pending_total <= revenue_due.size();
      checked_total <= checked_count;
   end

endmodule

// ===== tb/tb_rod_cutting_max_revenue_top.sv =====
// ----------------------------------------------------------------------------
// Rod-cutting maximum revenue engine testbench
// Drives price writes and solves into the engine with random idle gaps and
// response stalls, and lets a separate checker predict and compare every
// best-revenue result.
// ----------------------------------------------------------------------------
module tb_rod_cutting_max_revenue_top import rcmr_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_LEN      = DEF_MAX_LENGTH;
   localparam int RESET_CYCLES = 6;
   localparam int RANDOM_ITEMS = 280;
   localparam int LONG_HOLD    = 500;
   // Cycles of a solve on the longest rod.
   localparam int SOLVE_WORST  = MAX_LEN * (MAX_LEN + 1) / 2 + 3 * MAX_LEN + 2;
   localparam int DRAIN_CYCLES = SOLVE_WORST + 100;
   // Every item a worst-case solve with the longest sender gap and receiver
   // stall behind it, plus the clearing sweep, then doubled.
   localparam int CYCLE_LIMIT  = 2 * ((RANDOM_ITEMS + 60) * (SOLVE_WORST + 400 + 2 * LONG_HOLD)
                                      + MAX_LEN + DRAIN_CYCLES);

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [OPERATION_W-1:0]    req_operation = OP_WRITE;
   logic [LENGTH_W-1:0]       req_length = '0;
   logic [PRICE_W-1:0]        req_price = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [BEST_REVENUE_W-1:0] rsp_best_revenue;

   int unsigned fault_total;
   int unsigned pending_total;
   int unsigned checked_total;

   // Stimulus bookkeeping, used for the random budget and the summary.
   int unsigned useful_items = 0;
   int unsigned n_price_writes = 0;
   int unsigned n_ignored_writes = 0;
   int unsigned n_solves = 0;
   int unsigned n_clamped_solves = 0;
   int unsigned sender_quiet_left = 0;
   int unsigned cycle_count = 0;

   // The stimulus process asks for a long receiver hold-off by bumping
   // holds_wanted; the receiver process serves each request once.
   int unsigned holds_wanted = 0;
   int unsigned holds_served = 0;

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   rod_cutting_max_revenue_top uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_length       (req_length),
      .req_price        (req_price),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_best_revenue (rsp_best_revenue)
   );

   rod_cutting_max_revenue_checker #(.MAX_LEN(MAX_LEN)) revenue_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_length       (req_length),
      .req_price        (req_price),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_best_revenue (rsp_best_revenue),
      .fault_total      (fault_total),
      .pending_total    (pending_total),
      .checked_total    (checked_total)
   );

   // Length of an idle stretch: mostly none or short, now and then long.
   function automatic int idle_span();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 20);
      return $urandom_range(40, 200);
   endfunction

   // Offers one transaction and returns at the edge that accepted it, or
   // after the idle gap that follows it. The valid is never dropped and
   // raised within one step: it is only lowered when a gap follows.
   task automatic offer(input logic [OPERATION_W-1:0] op,
                        input logic [LENGTH_W-1:0]    len,
                        input logic [PRICE_W-1:0]     pr);
      int gap;
      req_valid     <= 1'b1;
      req_operation <= op;
      req_length    <= len;
      req_price     <= pr;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (op == OP_SOLVE) begin
         n_solves++;
         useful_items++;
         if (int'(len) > MAX_LEN) n_clamped_solves++;
      end else if (len >= 1 && int'(len) <= MAX_LEN) begin
         n_price_writes++;
         useful_items++;
      end else begin
         n_ignored_writes++;
      end
      if (sender_quiet_left > 0) begin
         sender_quiet_left--;
         gap = 0;
      end else begin
         if ($urandom_range(0, 19) == 0) sender_quiet_left = $urandom_range(10, 30);
         gap = idle_span();
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // The sender stops and waits until every predicted revenue has arrived.
   // The first edge lets the checker's count catch up with the last accept.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_total != 0) @(posedge clock);
   endtask

   // Back pressure: the receiver holds off for a long stretch while short
   // solves keep coming without gaps. The first result parks in the response
   // register, the next solve finishes behind it, and the input stalls.
   task automatic squeeze();
      holds_wanted <= holds_wanted + 1;
      sender_quiet_left = 8;
      repeat (8) offer(OP_SOLVE, LENGTH_W'($urandom_range(3, 9)), PRICE_W'($urandom()));
      wait_drained();
   endtask

   // Receiver: random stalls, quiet stretches with none, and the long
   // hold-offs that the stimulus asks for, all counted in cycles here.
   initial begin : rsp_side
      int stall_left;
      int quiet_left;
      stall_left = 0;
      quiet_left = 0;
      forever begin
         @(posedge clock);
         if (holds_served != holds_wanted) begin
            holds_served++;
            stall_left = LONG_HOLD;
         end else if (stall_left == 0) begin
            if (quiet_left > 0) begin
               quiet_left--;
            end else if ($urandom_range(0, 99) == 0) begin
               quiet_left = $urandom_range(50, 300);
            end else if ($urandom_range(0, 2) == 0) begin
               stall_left = idle_span();
            end
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Run stopped by the watchdog after %0d cycles", cycle_count);
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      int                     roll;
      int                     writes;
      int                     queries;
      bit                     squeezed_mid;
      logic [LENGTH_W-1:0]    wlen;
      logic [PRICE_W-1:0]     wprice;
      logic [LENGTH_W-1:0]    slen;
      squeezed_mid = 1'b0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed part. The engine sweeps its price memory right after reset
      // and stalls requests meanwhile; the handshake simply waits it out.
      // An untouched price table gives zero revenue at every length.
      offer(OP_SOLVE, '0, '0);
      offer(OP_SOLVE, LENGTH_W'(MAX_LEN), 16'hFFFF);
      // Writes at length zero or past the table must leave no trace.
      offer(OP_WRITE, '0, 16'hFFFF);
      offer(OP_WRITE, LENGTH_W'(MAX_LEN + 1), 16'hFFFF);
      offer(OP_WRITE, '1, 16'hFFFF);
      offer(OP_SOLVE, LENGTH_W'(MAX_LEN), '0);
      // Top price on unit pieces gives the largest revenue the field holds.
      offer(OP_WRITE, LENGTH_W'(1), 16'hFFFF);
      offer(OP_SOLVE, LENGTH_W'(1), '0);
      offer(OP_SOLVE, LENGTH_W'(MAX_LEN), '0);
      // Rod lengths past the table clamp to the longest rod.
      offer(OP_SOLVE, '1, '0);
      offer(OP_SOLVE, LENGTH_W'(MAX_LEN + 1), '0);
      // Only the full-length piece is priced: the rod one shorter earns zero.
      offer(OP_WRITE, LENGTH_W'(1), '0);
      offer(OP_WRITE, LENGTH_W'(MAX_LEN), 16'hFFFF);
      offer(OP_SOLVE, LENGTH_W'(MAX_LEN), '0);
      offer(OP_SOLVE, LENGTH_W'(MAX_LEN - 1), '0);
      // The textbook price list, where cutting beats selling whole.
      offer(OP_WRITE, LENGTH_W'(1), PRICE_W'(1));
      offer(OP_WRITE, LENGTH_W'(2), PRICE_W'(5));
      offer(OP_WRITE, LENGTH_W'(3), PRICE_W'(8));
      offer(OP_WRITE, LENGTH_W'(4), PRICE_W'(9));
      offer(OP_SOLVE, LENGTH_W'(4), '0);
      offer(OP_SOLVE, LENGTH_W'(7), '0);
      offer(OP_WRITE, LENGTH_W'(MAX_LEN), '0);
      offer(OP_SOLVE, '0, 16'hFFFF);

      squeeze();

      // Random part: mostly a handful of price writes followed by solves
      // over them, with fully random transactions mixed in as noise.
      useful_items = 0;
      while (useful_items < RANDOM_ITEMS) begin
         if (!squeezed_mid && useful_items >= RANDOM_ITEMS / 2) begin
            squeezed_mid = 1'b1;
            squeeze();
         end
         roll = $urandom_range(0, 99);
         if (roll < 75) begin
            writes = $urandom_range(1, 6);
            for (int k = 0; k < writes; k++) begin
               if ($urandom_range(0, 3) == 0) wlen = LENGTH_W'($urandom_range(1, MAX_LEN));
               else wlen = LENGTH_W'($urandom_range(1, 20));
               // Small prices make ties between cuts, near-top ones stress
               // the widest sums.
               case ($urandom_range(0, 3))
                  0: wprice = PRICE_W'($urandom_range(0, 15));
                  1: wprice = 16'hFFFF - PRICE_W'($urandom_range(0, 15));
                  default: wprice = PRICE_W'($urandom());
               endcase
               offer(OP_WRITE, wlen, wprice);
            end
            queries = $urandom_range(1, 3);
            for (int k = 0; k < queries; k++) begin
               // Long rods are slow, so most solves stay short.
               roll = $urandom_range(0, 99);
               if (roll < 80) slen = LENGTH_W'($urandom_range(0, 16));
               else if (roll < 95) slen = LENGTH_W'($urandom_range(17, MAX_LEN));
               else slen = LENGTH_W'($urandom_range(MAX_LEN + 1, 127));
               offer(OP_SOLVE, slen, PRICE_W'($urandom()));
            end
         end else begin
            offer(OPERATION_W'($urandom_range(0, 1)), LENGTH_W'($urandom_range(0, 127)),
                  PRICE_W'($urandom()));
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d price writes (%0d more ignored as out of range) and %0d solves",
               n_price_writes, n_ignored_writes, n_solves);
      $display("including %0d rods past the table; %0d revenues compared, %0d faults",
               n_clamped_solves, checked_total, fault_total);
      if (fault_total == 0 && pending_total == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
